// ===== hdl/ffgb_pkg.sv =====
// Shared widths, constants and divider interface types for the flat-field gain builder.
package ffgb_pkg;

   localparam int PIX_W   = 16;
   localparam int SUM_W   = 36;
   localparam int CNT_W   = 21;
   localparam int Q12_SH  = 12;
   localparam int QCNT_W  = 4;

   localparam logic [PIX_W-1:0] SAT16     = 16'hFFFF;
   localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_GAIN  = 1'b1;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] rem_init;
      logic [PIX_W-1:0] low_bits;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [PIX_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hdl/ffgb_divider.sv =====
// Radix-2 restoring divider with a saturated 16-bit quotient, one bit per cycle.
module ffgb_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ffgb_pkg::div_req_type req,
   output ffgb_pkg::div_rsp_type rsp
);
   import ffgb_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [PIX_W-1:0]  low_ff, low_in;
   logic [PIX_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W:0]    trial;

   // The partial remainder always stays below the divisor, so one extra bit holds the shift.
   assign trial = {rem_ff, low_ff[PIX_W-1]} - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         rem_in = req.rem_init;
         low_in = req.low_bits;
         dvs_in = req.divisor;
         cnt_in = '0;
         // A high part at or above the divisor means the quotient needs more than 16 bits.
         if (req.rem_init >= req.divisor) begin
            quo_in  = SAT16;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            quo_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         low_in = {low_ff[PIX_W-2:0], 1'b0};
         if (!trial[CNT_W]) begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[PIX_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[CNT_W-2:0], low_ff[PIX_W-1]};
            quo_in = {quo_ff[PIX_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == {QCNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== hdl/flat_field_gain_builder.sv =====
// Top level of the flat-field gain builder: pass control, totals and result register.
//
// Each input transfer carries a bright sample and its dark offset; req_tuser selects the
// accumulate pass (0) or the gain pass (1) and req_tlast marks the last pixel of a pass.
// An accumulate pixel that is not last gives no result. The last pixel of a non-empty
// accumulate pass and every gain pixel with a positive difference go through a shared
// radix-2 divider that retires one quotient bit per cycle; such an item passes through
// setup, the divider steps, the divider's done report and the load of the result
// register. When the quotient would not fit in 16 bits the divider saturates at once and
// skips its steps. A gain pixel whose difference is not positive, and the last pixel of
// an empty accumulate pass, skip the divider.
// Loading the result register waits for as long as an earlier result has not been taken.
// The result register lets a new item enter while a finished result waits to be taken.
module flat_field_gain_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] bright_pixel, [31:16] dark_pixel
   input  logic [0:0]  req_tuser,   // [0] operation
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] gain_word, [31:16] mean_level, [32] empty_error
   output logic [0:0]  rsp_tuser,   // [0] is_mean_report
   output logic        rsp_tlast    // last_gain
);
   import ffgb_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_SETUP = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic             op_ff, op_in;
   logic             last_ff, last_in;
   logic [PIX_W-1:0] bright_ff, bright_in;
   logic [PIX_W-1:0] dark_ff, dark_in;
   logic [PIX_W-1:0] diff_ff, diff_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PIX_W-1:0] mean_ff, mean_in;
   logic             empty_ff, empty_in;
   logic [PIX_W-1:0] gain_ff, gain_in;

   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_gain_ff, out_gain_in;
   logic [PIX_W-1:0] out_mean_ff, out_mean_in;
   logic             out_empty_ff, out_empty_in;
   logic             out_report_ff, out_report_in;
   logic             out_last_ff, out_last_in;

   logic [PIX_W:0]   diff_wide;
   logic             positive;
   logic [SUM_W:0]   sum_wide;
   logic             accept;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   ffgb_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign diff_wide  = {1'b0, bright_ff} - {1'b0, dark_ff};
   assign positive   = !diff_wide[PIX_W] && (diff_wide[PIX_W-1:0] != '0);
   assign sum_wide   = {1'b0, sum_ff} + {{(SUM_W+1-PIX_W){1'b0}}, diff_wide[PIX_W-1:0]};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      bright_in     = bright_ff;
      dark_in       = dark_ff;
      diff_in       = diff_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      mean_in       = mean_ff;
      empty_in      = empty_ff;
      gain_in       = gain_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_gain_in   = out_gain_ff;
      out_mean_in   = out_mean_ff;
      out_empty_in  = out_empty_ff;
      out_report_in = out_report_ff;
      out_last_in   = out_last_ff;
      div_req       = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_tuser[0];
               last_in   = req_tlast;
               bright_in = req_tdata[PIX_W-1:0];
               dark_in   = req_tdata[2*PIX_W-1:PIX_W];
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            diff_in = diff_wide[PIX_W-1:0];
            if (op_ff == OP_ACCUM) begin
               if (positive) begin
                  sum_in = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               state_in = last_ff ? S_SETUP : S_IDLE;
            end else if (!positive) begin
               gain_in  = SAT16;
               state_in = S_DONE;
            end else begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (op_ff == OP_ACCUM) begin
               sum_in   = '0;
               count_in = '0;
               gain_in  = '0;
               if (count_ff == '0) begin
                  empty_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.rem_init = {1'b0, sum_ff[SUM_W-1:PIX_W]};
                  div_req.low_bits = sum_ff[PIX_W-1:0];
                  div_req.divisor  = count_ff;
                  state_in         = S_DIV;
               end
            end else begin
               // Dividend is mean * 4096, split at bit 16 for the divider.
               div_req.start    = 1'b1;
               div_req.rem_init = {{(CNT_W-Q12_SH){1'b0}},
                                   mean_ff[PIX_W-1:PIX_W-Q12_SH]};
               div_req.low_bits = {mean_ff[PIX_W-Q12_SH-1:0], {Q12_SH{1'b0}}};
               div_req.divisor  = {{(CNT_W-PIX_W){1'b0}}, diff_ff};
               state_in         = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (op_ff == OP_ACCUM) begin
                  mean_in  = div_rsp.quotient;
                  empty_in = 1'b0;
               end else begin
                  gain_in = div_rsp.quotient;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in  = 1'b1;
               out_gain_in   = gain_ff;
               out_mean_in   = mean_ff;
               out_empty_in  = empty_ff;
               out_report_in = (op_ff == OP_ACCUM);
               out_last_in   = (op_ff == OP_GAIN) && last_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         mean_ff      <= '0;
         empty_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         empty_ff     <= empty_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff         <= op_in;
      last_ff       <= last_in;
      bright_ff     <= bright_in;
      dark_ff       <= dark_in;
      diff_ff       <= diff_in;
      gain_ff       <= gain_in;
      out_gain_ff   <= out_gain_in;
      out_mean_ff   <= out_mean_in;
      out_empty_ff  <= out_empty_in;
      out_report_ff <= out_report_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_empty_ff, out_mean_ff, out_gain_ff};
   assign rsp_tuser  = out_report_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
